// ----- sv/salc_pkg.sv -----
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants and types for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package salc_pkg;

    // default sizing of the tag store
    localparam int MAX_SETS_DEF   = 1024;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 32;

    // configuration register widths
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;
    localparam int ADDR_BITS_W  = 6;
    localparam int INDEX_BITS_W = 4;
    localparam int OFFSET_BITS_W = 5;
    localparam int WAYS_W       = 4;

    // configuration reset values
    localparam logic [ADDR_BITS_W-1:0]   ADDR_BITS_RST   = 6'd32;
    localparam logic [INDEX_BITS_W-1:0]  INDEX_BITS_RST  = 4'd4;
    localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 5'd2;
    localparam logic [WAYS_W-1:0]        WAYS_RST        = 4'd2;

    // miss counter width
    localparam int MISS_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDR_BITS   = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_OFFSET_BITS = 2'd2,
        CFG_WAYS        = 2'd3
    } t_cfg_idx;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EVAL
    } t_back_state;

endpackage

// ----- sv/salc_front.sv -----
// ----------------------------------------------------------------------------
// salc_front
// Request intake: masks the address and splits it into set index and tag.
// ----------------------------------------------------------------------------
module salc_front #(
    parameter int MAX_SETS   = salc_pkg::MAX_SETS_DEF,
    parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_DEF,
    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int REQ_W     = SET_W + ADDR_WIDTH
) (
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [ADDR_WIDTH-1:0]                  i_address,
    input  logic [salc_pkg::ADDR_BITS_W-1:0]       i_address_bits,
    input  logic [salc_pkg::INDEX_BITS_W-1:0]      i_index_bits,
    input  logic [salc_pkg::OFFSET_BITS_W-1:0]     i_offset_bits,
    input  logic                                   i_q_full,
    input  logic                                   i_clear_busy,
    output logic                                   o_push,
    output logic [REQ_W-1:0]                       o_req
);

    // largest usable index width: floor(log2(MAX_SETS))
    localparam int MIB = $clog2(MAX_SETS + 1) - 1;

    logic [6:0]            ab_c;
    logic [4:0]            ib_c;
    logic [5:0]            shift;
    logic [ADDR_WIDTH-1:0] addr_m;
    logic [ADDR_WIDTH-1:0] addr_sh;
    logic [SET_W-1:0]      set_idx;
    logic [ADDR_WIDTH-1:0] tag;

    // clamp address and index widths into their legal range
    always_comb begin
        if (i_address_bits == '0) begin
            ab_c = 7'd1;
        end else if ({1'b0, i_address_bits} > 7'(ADDR_WIDTH)) begin
            ab_c = 7'(ADDR_WIDTH);
        end else begin
            ab_c = {1'b0, i_address_bits};
        end
        if ({1'b0, i_index_bits} > 5'(MIB)) begin
            ib_c = 5'(MIB);
        end else begin
            ib_c = {1'b0, i_index_bits};
        end
    end

    // address split
    assign addr_m  = i_address & ~({ADDR_WIDTH{1'b1}} << ab_c);
    assign addr_sh = addr_m >> i_offset_bits;
    assign set_idx = SET_W'(addr_sh) & ~({SET_W{1'b1}} << ib_c);
    assign shift   = 6'(i_offset_bits) + 6'(ib_c);
    assign tag     = addr_m >> shift;

    // handshake: hold off while the queue is full or the store is clearing
    assign o_ready = !i_q_full && !i_clear_busy;
    assign o_push  = i_valid && o_ready;
    assign o_req   = {set_idx, tag};

endmodule

// ----- sv/salc_fifo.sv -----
// ----------------------------------------------------------------------------
// salc_fifo
// Two-entry request queue between the intake and the tag-store sequencer.
// ----------------------------------------------------------------------------
module salc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_data[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/salc_back.sv -----
// ----------------------------------------------------------------------------
// salc_back
// Tag-store sequencer: set read, tag match, LRU update, write-back, result.
// ----------------------------------------------------------------------------
module salc_back #(
    parameter int MAX_SETS   = salc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = salc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_DEF,
    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int REQ_W     = SET_W + ADDR_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [salc_pkg::WAYS_W-1:0]       i_ways_in_use,
    input  logic                              i_req_valid,
    input  logic [REQ_W-1:0]                  i_req,
    output logic                              o_req_pop,
    output logic                              o_clear_busy,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_hit,
    output logic [salc_pkg::MISS_W-1:0]       o_miss_total
);

    localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RW-1:0]    RANK_MAX = RW'(MAX_WAYS - 1);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

    // set-wide storage: valid bits, recency ranks, tags
    logic [MAX_WAYS-1:0]                 r_mem_valid [MAX_SETS];
    logic [MAX_WAYS-1:0][RW-1:0]         r_mem_rank  [MAX_SETS];
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] r_mem_tag   [MAX_SETS];

    salc_pkg::t_back_state r_state, n_state;

    logic [SET_W-1:0]                    r_clr_cnt;
    logic [SET_W-1:0]                    r_set;
    logic [ADDR_WIDTH-1:0]               r_tag;
    logic [MAX_WAYS-1:0]                 r_rd_valid;
    logic [MAX_WAYS-1:0][RW-1:0]         r_rd_rank;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] r_rd_tag;
    logic [salc_pkg::MISS_W-1:0]         r_miss;
    logic                                r_out_valid;
    logic                                r_out_hit;
    logic [salc_pkg::MISS_W-1:0]         r_out_miss;

    logic [SET_W-1:0]                    req_set;
    logic [ADDR_WIDTH-1:0]               req_tag;
    logic                                rd_en;
    logic                                wr_en;
    logic                                out_load;
    logic [SET_W-1:0]                    wr_addr;
    logic [MAX_WAYS-1:0]                 wr_valid;
    logic [MAX_WAYS-1:0][RW-1:0]         wr_rank;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] wr_tag;

    logic [4:0]                          nw;
    logic [MAX_WAYS-1:0]                 en;
    logic [MAX_WAYS-1:0]                 hitv;
    logic [MAX_WAYS-1:0]                 inv;
    logic                                hit;
    logic                                found;
    logic [RW-1:0]                       hway;
    logic [RW-1:0]                       iway;
    logic [RW-1:0]                       vway;
    logic [RW-1:0]                       way;
    logic [RW-1:0]                       old_rank;
    logic                                bump_all;
    logic [MAX_WAYS-1:0]                 upd_valid;
    logic [MAX_WAYS-1:0][RW-1:0]         upd_rank;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] upd_tag;
    logic [salc_pkg::MISS_W-1:0]         n_miss;

    assign req_set = i_req[REQ_W-1:ADDR_WIDTH];
    assign req_tag = i_req[ADDR_WIDTH-1:0];

    // match, replacement choice and LRU update on the registered set
    always_comb begin
        if (i_ways_in_use == '0) begin
            nw = 5'd1;
        end else if ({1'b0, i_ways_in_use} > 5'(MAX_WAYS)) begin
            nw = 5'(MAX_WAYS);
        end else begin
            nw = {1'b0, i_ways_in_use};
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            en[w]   = (5'(w) < nw);
            hitv[w] = en[w] && r_rd_valid[w] && (r_rd_tag[w] == r_tag);
            inv[w]  = en[w] && !r_rd_valid[w];
        end
        hit   = |hitv;
        found = |inv;
        // lowest matching way, lowest invalid way
        hway = '0;
        iway = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hitv[w]) begin
                hway = RW'(w);
            end
            if (inv[w]) begin
                iway = RW'(w);
            end
        end
        // oldest way, ties to the lowest way number
        vway = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (en[w] && (r_rd_rank[w] > r_rd_rank[vway])) begin
                vway = RW'(w);
            end
        end
        if (hit) begin
            way = hway;
        end else if (found) begin
            way = iway;
        end else begin
            way = vway;
        end
        bump_all = !hit && found;
        old_rank = r_rd_rank[way];
        // age the younger valid ways, make the touched way newest
        for (int w = 0; w < MAX_WAYS; w++) begin
            upd_rank[w] = r_rd_rank[w];
            if (en[w] && (RW'(w) != way) && r_rd_valid[w]
                && (bump_all || (r_rd_rank[w] < old_rank))
                && (r_rd_rank[w] < RANK_MAX)) begin
                upd_rank[w] = r_rd_rank[w] + RW'(1);
            end
        end
        upd_rank[way]  = '0;
        upd_valid      = r_rd_valid;
        upd_valid[way] = 1'b1;
        upd_tag        = r_rd_tag;
        if (!hit) begin
            upd_tag[way] = r_tag;
        end
        if (!hit && (r_miss != '1)) begin
            n_miss = r_miss + 1'b1;
        end else begin
            n_miss = r_miss;
        end
    end

    // sequencer: clear sweep, then read a set and write it back
    always_comb begin
        n_state   = r_state;
        o_req_pop = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        out_load  = 1'b0;
        wr_addr   = r_set;
        wr_valid  = upd_valid;
        wr_rank   = upd_rank;
        wr_tag    = upd_tag;
        case (r_state)
            salc_pkg::BK_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = r_clr_cnt;
                wr_valid = '0;
                wr_rank  = '0;
                wr_tag   = '0;
                if (r_clr_cnt == LAST_SET) begin
                    n_state = salc_pkg::BK_IDLE;
                end
            end
            salc_pkg::BK_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    rd_en     = 1'b1;
                    n_state   = salc_pkg::BK_EVAL;
                end
            end
            salc_pkg::BK_EVAL: begin
                if (!r_out_valid || i_ready) begin
                    wr_en    = 1'b1;
                    out_load = 1'b1;
                    n_state  = salc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = salc_pkg::BK_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= salc_pkg::BK_CLEAR;
            r_clr_cnt   <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == salc_pkg::BK_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (out_load) begin
                r_miss      <= n_miss;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_set <= req_set;
            r_tag <= req_tag;
        end
        if (out_load) begin
            r_out_hit  <= hit;
            r_out_miss <= n_miss;
        end
    end

    // tag store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_valid[wr_addr] <= wr_valid;
            r_mem_rank[wr_addr]  <= wr_rank;
            r_mem_tag[wr_addr]   <= wr_tag;
        end
        if (rd_en) begin
            r_rd_valid <= r_mem_valid[req_set];
            r_rd_rank  <= r_mem_rank[req_set];
            r_rd_tag   <= r_mem_tag[req_set];
        end
    end

    assign o_clear_busy = (r_state == salc_pkg::BK_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_miss_total = r_out_miss;

endmodule

// ----- sv/set_assoc_lru_cache_tags.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_address) takes one address per request.
//   Output channel (o_valid/i_ready, o_hit, o_miss_total) returns one result
//   per request, in order: hit flag and a saturating miss count since reset.
//   Config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes address_bits,
//   index_bits, offset_bits and ways_in_use; write only while idle.
// Timing:
//   An accepted request is split into set and tag and queued (two entries).
//   The sequencer then takes each request through two states: BK_IDLE reads
//   the set from the tag store, BK_EVAL matches, updates LRU ranks and writes
//   the set back, and waits while a stalled result holds the output register.
//   A new request is taken only after the last is written back, and reaches
//   o_valid through the queue, the set read and the output register.
// Reset:
//   After reset the store clears its valid bits and ranks one set per cycle,
//   through all MAX_SETS sets (1024 by default); o_ready stays low meanwhile.
// Backpressure:
//   A result waits in the output register while i_ready is low; the queue
//   keeps taking requests until full, then o_ready drops.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
    parameter int MAX_SETS   = salc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = salc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ADDR_WIDTH-1:0]               i_address,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic [salc_pkg::MISS_W-1:0]         o_miss_total,
    input  logic                                i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int REQ_W = SET_W + ADDR_WIDTH;

    logic [salc_pkg::ADDR_BITS_W-1:0]   r_address_bits;
    logic [salc_pkg::INDEX_BITS_W-1:0]  r_index_bits;
    logic [salc_pkg::OFFSET_BITS_W-1:0] r_offset_bits;
    logic [salc_pkg::WAYS_W-1:0]        r_ways_in_use;

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    logic [REQ_W-1:0] q_in;
    logic [REQ_W-1:0] q_out;
    logic             clear_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_bits <= salc_pkg::ADDR_BITS_RST;
            r_index_bits   <= salc_pkg::INDEX_BITS_RST;
            r_offset_bits  <= salc_pkg::OFFSET_BITS_RST;
            r_ways_in_use  <= salc_pkg::WAYS_RST;
        end else if (i_cfg_we) begin
            case (salc_pkg::t_cfg_idx'(i_cfg_idx))
                salc_pkg::CFG_ADDR_BITS:   r_address_bits <= i_cfg_data[5:0];
                salc_pkg::CFG_INDEX_BITS:  r_index_bits   <= i_cfg_data[3:0];
                salc_pkg::CFG_OFFSET_BITS: r_offset_bits  <= i_cfg_data[4:0];
                salc_pkg::CFG_WAYS:        r_ways_in_use  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // intake and address split
    salc_front #(
        .MAX_SETS   (MAX_SETS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_address      (i_address),
        .i_address_bits (r_address_bits),
        .i_index_bits   (r_index_bits),
        .i_offset_bits  (r_offset_bits),
        .i_q_full       (q_full),
        .i_clear_busy   (clear_busy),
        .o_push         (q_push),
        .o_req          (q_in)
    );

    // request queue
    salc_fifo #(
        .WIDTH (REQ_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // tag store and LRU sequencer
    salc_back #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ways_in_use (r_ways_in_use),
        .i_req_valid   (!q_empty),
        .i_req         (q_out),
        .o_req_pop     (q_pop),
        .o_clear_busy  (clear_busy),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_miss_total  (o_miss_total)
    );

endmodule

// ----- sv/salc_check.sv -----
// ----------------------------------------------------------------------------
// salc_check
// Port-level checks for the LRU tag store, bound to the top level.
// ----------------------------------------------------------------------------
module salc_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_hit,
    input logic [salc_pkg::MISS_W-1:0] o_miss_total
);

    logic [salc_pkg::MISS_W-1:0] r_last_miss;

    // miss count of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_miss <= '0;
        end else if (o_valid && i_ready) begin
            r_last_miss <= o_miss_total;
        end
    end

    // the store clears after reset, so no request is taken the next cycle
    a_no_accept_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request accepted during clear sweep");

    // no result right after reset
    a_no_result_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit) && $stable(o_miss_total))
        else $error("stalled result changed");

    // a hit leaves the miss count unchanged
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_miss_total == r_last_miss)
        else $error("miss count moved on a hit");

    // a miss advances the count by one, saturating
    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |->
            ((r_last_miss == '1) ? (o_miss_total == '1)
                                 : (o_miss_total == r_last_miss + 1'b1)))
        else $error("miss count did not advance on a miss");

endmodule

bind set_assoc_lru_cache_tags salc_check u_salc_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_hit        (o_hit),
    .o_miss_total (o_miss_total)
);
